>>> rtl/core/fac_pkg.sv
`default_nettype none

package fac_pkg;

	// plane register word layout
	localparam int NORMAL_W  = 16;
	localparam int OFFSET_W  = 16;
	localparam int PLANE_W   = 64;
	localparam int REG_COUNT = 6;
	localparam int CFG_IDX_W = 3;
	localparam int AXES      = 3;
	localparam int CORNERS   = 8;

	localparam logic [1:0] VERDICT_OUTSIDE   = 2'd0;
	localparam logic [1:0] VERDICT_INSIDE    = 2'd1;
	localparam logic [1:0] VERDICT_INTERSECT = 2'd2;

	// load enables of the three plane stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

endpackage

`default_nettype wire

>>> rtl/core/fac_plane_eval.sv
`default_nettype none

module fac_plane_eval #(
	parameter int COORD_WIDTH      = 16,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  wire logic                                  clk,
	input  wire fac_pkg::stage_en_t                    en,
	input  wire logic [fac_pkg::PLANE_W-1:0]           plane,
	input  wire logic signed [COORD_WIDTH-1:0]         lo [fac_pkg::AXES],
	input  wire logic signed [COORD_WIDTH-1:0]         hi [fac_pkg::AXES],
	output logic [fac_pkg::CORNERS-1:0]                inside_s3
);

	localparam int PW  = fac_pkg::NORMAL_W + COORD_WIDTH;
	localparam int OW  = fac_pkg::OFFSET_W + NORMAL_FRAC_BITS;
	localparam int MW  = (PW > OW) ? PW : OW;
	localparam int XYW = PW + 1;
	localparam int ZWW = MW + 1;
	localparam int SW  = MW + 2;

	logic signed [fac_pkg::NORMAL_W-1:0] normal [fac_pkg::AXES];
	logic signed [fac_pkg::OFFSET_W-1:0] offset;

	logic signed [PW-1:0]  prod_lo_s1 [fac_pkg::AXES];
	logic signed [PW-1:0]  prod_hi_s1 [fac_pkg::AXES];
	logic signed [OW-1:0]  offset_s1;
	logic signed [XYW-1:0] xy_s2 [4];
	logic signed [ZWW-1:0] zw_s2 [2];

	always_comb begin
		for (int a = 0; a < fac_pkg::AXES; a++) begin
			normal[a] = plane[a*fac_pkg::NORMAL_W +: fac_pkg::NORMAL_W];
		end
		offset = plane[fac_pkg::AXES*fac_pkg::NORMAL_W +: fac_pkg::OFFSET_W];
	end

	// one product per axis and bound, shared by the four corners that use it
	always_ff @(posedge clk) begin
		if (en.s1) begin
			for (int a = 0; a < fac_pkg::AXES; a++) begin
				prod_lo_s1[a] <= PW'(normal[a]) * PW'(lo[a]);
				prod_hi_s1[a] <= PW'(normal[a]) * PW'(hi[a]);
			end
			offset_s1 <= OW'(offset) <<< NORMAL_FRAC_BITS;
		end
	end

	// corner bit 0 picks x bound, bit 1 y bound, bit 2 z bound
	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int c = 0; c < 4; c++) begin
				xy_s2[c] <= XYW'(c[0] ? prod_hi_s1[0] : prod_lo_s1[0])
				          + XYW'(c[1] ? prod_hi_s1[1] : prod_lo_s1[1]);
			end
			zw_s2[0] <= ZWW'(prod_lo_s1[2]) + ZWW'(offset_s1);
			zw_s2[1] <= ZWW'(prod_hi_s1[2]) + ZWW'(offset_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int c = 0; c < fac_pkg::CORNERS; c++) begin
				inside_s3[c] <= !(SW'(xy_s2[c % 4]) + SW'(zw_s2[c / 4]) < 0);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/frustum_aabb_classify.sv
`default_nettype none

// an accepted box passes the product, partial-sum, compare and verdict registers to its verdict word
// throughput: one box per cycle unless the master side stalls; all 36 corner-term multipliers work in stage one
// a stalled stage holds its word and stages that feed a bubble keep moving
// reset clears the stage valid bits and zeroes every plane register, so after
// reset every box classifies as inside until the planes are written

module frustum_aabb_classify #(
	parameter int NUM_PLANES       = 6,
	parameter int COORD_WIDTH      = 16,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,

	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// min_x, min_y, min_z, max_x, max_y, max_z, zero fill
	input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,

	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// verdict, zero fill
	output logic [7:0]                                m_tdata,

	input  wire logic                                 cfg_we,
	input  wire logic [fac_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [fac_pkg::PLANE_W-1:0]          cfg_data
);

	logic [fac_pkg::PLANE_W-1:0] plane_q [fac_pkg::REG_COUNT];
	logic [fac_pkg::PLANE_W-1:0] plane_w [NUM_PLANES];

	logic signed [COORD_WIDTH-1:0] lo [fac_pkg::AXES];
	logic signed [COORD_WIDTH-1:0] hi [fac_pkg::AXES];

	logic [fac_pkg::CORNERS-1:0] inside_s3 [NUM_PLANES];

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready1, ready2, ready3, ready4;
	fac_pkg::stage_en_t en;

	logic [1:0] verdict_s4;
	logic [1:0] verdict_next;
	logic       any_out;
	logic       all_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < fac_pkg::REG_COUNT; r++) begin
				plane_q[r] <= '0;
			end
		end else begin
			for (int r = 0; r < fac_pkg::REG_COUNT; r++) begin
				if (cfg_we && cfg_index == fac_pkg::CFG_IDX_W'(r)) begin
					plane_q[r] <= cfg_data;
				end
			end
		end
	end

	always_comb begin
		for (int a = 0; a < fac_pkg::AXES; a++) begin
			lo[a] = s_tdata[a*COORD_WIDTH +: COORD_WIDTH];
			hi[a] = s_tdata[(a+fac_pkg::AXES)*COORD_WIDTH +: COORD_WIDTH];
		end
	end

	// a stage loads when it is empty or its word moves on
	assign ready4   = !valid_s4 || m_tready;
	assign ready3   = !valid_s3 || ready4;
	assign ready2   = !valid_s2 || ready3;
	assign ready1   = !valid_s1 || ready2;
	assign s_tready = ready1;
	assign en.s1    = ready1;
	assign en.s2    = ready2;
	assign en.s3    = ready3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready1) valid_s1 <= s_tvalid;
			if (ready2) valid_s2 <= valid_s1;
			if (ready3) valid_s3 <= valid_s2;
			if (ready4) valid_s4 <= valid_s3;
		end
	end

	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
		// slots without a register stay zero and pass every corner
		if (p < fac_pkg::REG_COUNT) begin : g_reg
			assign plane_w[p] = plane_q[p];
		end else begin : g_zero
			assign plane_w[p] = '0;
		end

		fac_plane_eval #(
			.COORD_WIDTH      (COORD_WIDTH),
			.NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
		) u_eval (
			.clk       (clk),
			.en        (en),
			.plane     (plane_w[p]),
			.lo        (lo),
			.hi        (hi),
			.inside_s3 (inside_s3[p])
		);
	end

	always_comb begin
		any_out = 1'b0;
		all_in  = 1'b1;
		for (int p = 0; p < NUM_PLANES; p++) begin
			if (inside_s3[p] == '0) any_out = 1'b1;
			if (inside_s3[p] != '1) all_in = 1'b0;
		end
		if (any_out) begin
			verdict_next = fac_pkg::VERDICT_OUTSIDE;
		end else if (all_in) begin
			verdict_next = fac_pkg::VERDICT_INSIDE;
		end else begin
			verdict_next = fac_pkg::VERDICT_INTERSECT;
		end
	end

	always_ff @(posedge clk) begin
		if (ready4) begin
			verdict_s4 <= verdict_next;
		end
	end

	assign m_tvalid = valid_s4;
	assign m_tdata  = {6'b0, verdict_s4};

endmodule

`default_nettype wire

>>> sim/tb_frustum_aabb_classify.sv
`timescale 1ns / 100ps

module tb_frustum_aabb_classify;

	localparam int COORD_W     = 16;
	localparam int NORM_FRAC   = 14;
	localparam int DATA_W      = ((6*COORD_W+7)/8)*8;
	localparam int ONE         = 1 << NORM_FRAC;
	localparam int LATENCY     = 4;
	localparam int ROUNDS      = 6;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum logic [fac_pkg::CFG_IDX_W-1:0] {
		REG_LEFT, REG_RIGHT, REG_NEAR, REG_FAR, REG_BELOW, REG_ABOVE, REG_SPARE6, REG_SPARE7
	} plane_idx_t;

	// first member sits in the top bits, so min_x lands at bit 0
	typedef struct packed {
		logic signed [COORD_W-1:0] max_z;
		logic signed [COORD_W-1:0] max_y;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] min_z;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] min_x;
	} aabb_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [DATA_W-1:0]             s_tdata;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [7:0]                    m_tdata;
	logic                          cfg_we;
	logic [fac_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [fac_pkg::PLANE_W-1:0]   cfg_data;

	logic [fac_pkg::PLANE_W-1:0] plane_model [fac_pkg::REG_COUNT];
	logic [1:0]         pending_verdicts [$];
	logic [1:0]         want;
	int                 verdict_tally [3];
	int                 send_idle_pct;
	int                 recv_idle_pct;
	int                 mismatch_count = 0;
	int                 cycle_count = 0;
	int                 boxes_sent = 0;
	int                 plane_settings = 0;

	frustum_aabb_classify uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("run exceeded %0d cycles", CYCLE_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	// exact corner-by-plane classification of one box
	function automatic logic [1:0] classify_box(input aabb_t b);
		longint lo [3];
		longint hi [3];
		longint nx, ny, nz, w, x, y, z, sum;
		int passed, outside;
		logic [fac_pkg::PLANE_W-1:0] pl;
		lo[0] = b.min_x; lo[1] = b.min_y; lo[2] = b.min_z;
		hi[0] = b.max_x; hi[1] = b.max_y; hi[2] = b.max_z;
		passed = 0;
		for (int p = 0; p < fac_pkg::REG_COUNT; p++) begin
			pl = plane_model[p];
			nx = $signed(pl[15:0]);
			ny = $signed(pl[31:16]);
			nz = $signed(pl[47:32]);
			w  = $signed(pl[63:48]);
			outside = 0;
			for (int c = 0; c < fac_pkg::CORNERS; c++) begin
				x = c[0] ? hi[0] : lo[0];
				y = c[1] ? hi[1] : lo[1];
				z = c[2] ? hi[2] : lo[2];
				sum = nx*x + ny*y + nz*z + w*(longint'(1) << NORM_FRAC);
				if (sum >= 0)
					passed++;
				else
					outside++;
			end
			if (outside == fac_pkg::CORNERS)
				return fac_pkg::VERDICT_OUTSIDE;
		end
		return (passed == fac_pkg::REG_COUNT*fac_pkg::CORNERS) ?
			fac_pkg::VERDICT_INSIDE : fac_pkg::VERDICT_INTERSECT;
	endfunction

	function automatic logic [fac_pkg::PLANE_W-1:0] plane_word(input int nx, ny, nz, w);
		return {w[15:0], nz[15:0], ny[15:0], nx[15:0]};
	endfunction

	function automatic aabb_t make_box(input int x0, y0, z0, x1, y1, z1);
		aabb_t b;
		b.min_x = x0[15:0]; b.min_y = y0[15:0]; b.min_z = z0[15:0];
		b.max_x = x1[15:0]; b.max_y = y1[15:0]; b.max_z = z1[15:0];
		return b;
	endfunction

	// mostly well-formed boxes near the frustum, some raw noise, some swapped
	function automatic aabb_t random_box();
		int ctr, half, pick;
		int lo [3];
		int hi [3];
		aabb_t b;
		logic [COORD_W-1:0] tmp;
		pick = $urandom_range(99);
		if (pick < 15)
			return aabb_t'({$urandom, $urandom, $urandom});
		for (int a = 0; a < 3; a++) begin
			ctr = int'($urandom_range(6000)) - 3000;
			half = (pick < 25) ? 0 : int'($urandom_range(800));
			lo[a] = ctr - half;
			hi[a] = ctr + half;
		end
		b = make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
		if (pick >= 90) begin
			case ($urandom_range(2))
				0: begin tmp = b.min_x; b.min_x = b.max_x; b.max_x = tmp; end
				1: begin tmp = b.min_y; b.min_y = b.max_y; b.max_y = tmp; end
				default: begin tmp = b.min_z; b.min_z = b.max_z; b.max_z = tmp; end
			endcase
		end
		return b;
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	// predict on every accepted box word
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			pending_verdicts.push_back(classify_box(aabb_t'(s_tdata)));
			boxes_sent++;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_verdicts.size() == 0) begin
				flag_mismatch($sformatf("verdict word %0h with no box pending", m_tdata));
			end else begin
				want = pending_verdicts.pop_front();
				verdict_tally[want]++;
				if (m_tdata !== {6'd0, want})
					flag_mismatch($sformatf("verdict word %0h, expected %0h", m_tdata, want));
			end
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_box(input aabb_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= {$urandom, $urandom, $urandom};
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (2*LATENCY) @(posedge clk);
	endtask

	// leaves cfg_we high; the caller drops it after the last write
	task automatic write_plane(input plane_idx_t idx, input logic [fac_pkg::PLANE_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		if (idx < fac_pkg::REG_COUNT)
			plane_model[idx] = value;
	endtask

	task automatic program_planes(input logic [fac_pkg::PLANE_W-1:0] l, r, n, f, b, a);
		logic [fac_pkg::PLANE_W-1:0] vals [fac_pkg::REG_COUNT];
		vals[0] = l; vals[1] = r; vals[2] = n; vals[3] = f; vals[4] = b; vals[5] = a;
		for (int i = 0; i < fac_pkg::REG_COUNT; i++)
			write_plane(plane_idx_t'(i), vals[i]);
		cfg_we <= 1'b0;
		plane_settings++;
	endtask

	// 0: tight tilted frustum, 1: wide offsets, 2: raw bits, 3: tight with a zero plane
	task automatic program_random_planes(input int kind);
		logic [fac_pkg::PLANE_W-1:0] v [fac_pkg::REG_COUNT];
		int nrm [3];
		int axis, off;
		for (int i = 0; i < fac_pkg::REG_COUNT; i++) begin
			axis = (i < 2) ? 0 : (i < 4) ? 2 : 1;
			for (int k = 0; k < 3; k++)
				nrm[k] = int'($urandom_range(4000)) - 2000;
			nrm[axis] = (i % 2 == 0) ? ONE : -ONE;
			off = (kind == 1) ? int'($urandom_range(32767)) : int'($urandom_range(300, 3000));
			v[i] = (kind == 2) ? {$urandom, $urandom} : plane_word(nrm[0], nrm[1], nrm[2], off);
		end
		if (kind == 3)
			v[$urandom_range(fac_pkg::REG_COUNT-1)] = '0;
		program_planes(v[0], v[1], v[2], v[3], v[4], v[5]);
	endtask

	// zero planes pass every corner
	task automatic test_reset_planes();
		send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
		send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
		send_box(make_box(-32768, 32767, -32768, 32767, -32768, 32767));
		drain();
	endtask

	// the two spare indexes must not reach any plane
	task automatic test_unused_index();
		write_plane(REG_SPARE6, '1);
		write_plane(REG_SPARE7, plane_word(ONE, 0, 0, -100));
		cfg_we <= 1'b0;
		send_box(make_box(-500, -500, -500, -400, -400, -400));
		send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
		drain();
	endtask

	task automatic test_axis_frustum();
		program_planes(plane_word(ONE, 0, 0, 1000), plane_word(-ONE, 0, 0, 1000),
			plane_word(0, 0, ONE, 1000), plane_word(0, 0, -ONE, 1000),
			plane_word(0, ONE, 0, 1000), plane_word(0, -ONE, 0, 1000));
		send_box(make_box(-10, -10, -10, 10, 10, 10));
		// corners exactly on the planes count as inside
		send_box(make_box(-1000, -1000, -1000, 1000, 1000, 1000));
		send_box(make_box(-1001, 0, 0, -1001, 0, 0));
		send_box(make_box(2000, 2000, 2000, 3000, 3000, 3000));
		send_box(make_box(-2000, -5, -5, 0, 5, 5));
		send_box(make_box(10, 10, 10, -10, -10, -10));
		send_box(make_box(1500, 0, 0, -1500, 0, 0));
		send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
		drain();
	endtask

	task automatic test_extreme_planes();
		for (int s = 0; s < 2; s++) begin
			if (s == 0)
				program_planes('1, '1, '1, '1, '1, '1);
			else
				program_planes(plane_word(-32768, 32767, -32768, 32767),
					plane_word(32767, -32768, 32767, -32768),
					plane_word(-32768, -32768, -32768, 32767),
					plane_word(32767, 32767, 32767, 32767),
					plane_word(32767, -32768, -32768, -32768),
					plane_word(-32768, 32767, 32767, 32767));
			send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
			send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
			send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
			drain();
		end
	endtask

	task automatic test_random_boxes(input int send_pct, recv_pct, n_boxes);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int r = 0; r < ROUNDS; r++) begin
			drain();
			program_random_planes(r % 4);
			repeat (n_boxes / ROUNDS) send_box(random_box());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 15;
		recv_idle_pct = 84;
		for (int i = 0; i < fac_pkg::REG_COUNT; i++)
			plane_model[i] = '0;
		for (int i = 0; i < 3; i++)
			verdict_tally[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_planes();
		test_unused_index();
		test_axis_frustum();
		test_extreme_planes();
		test_random_boxes(15, 84, 516);
		test_random_boxes(84, 15, 516);
		test_random_boxes(0, 0, 516);
		drain();

		$display("classified %0d boxes under %0d plane settings across three stall mixes",
			boxes_sent, plane_settings);
		$display("verdicts seen: %0d outside, %0d inside, %0d intersect; %0d mismatches",
			verdict_tally[fac_pkg::VERDICT_OUTSIDE], verdict_tally[fac_pkg::VERDICT_INSIDE],
			verdict_tally[fac_pkg::VERDICT_INTERSECT], mismatch_count);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> frustum_aabb_classify.f
rtl/core/fac_pkg.sv
rtl/core/fac_plane_eval.sv
rtl/core/frustum_aabb_classify.sv
sim/tb_frustum_aabb_classify.sv
